// ===== hdl/hpm_pkg.sv =====
// package for the homography point map: fixed-point constants, types and the divide step
`default_nettype none
package hpm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SHIFT     = 32 - FRAC_BITS;
    localparam int QBITS     = 32;
    localparam int SUM_W     = 66;

    localparam logic [2:0] REG_ROW0_LINEAR = 3'd0;
    localparam logic [2:0] REG_ROW0_OFFSET = 3'd1;
    localparam logic [2:0] REG_ROW1_LINEAR = 3'd2;
    localparam logic [2:0] REG_ROW1_OFFSET = 3'd3;
    localparam logic [2:0] REG_ROW2_LINEAR = 3'd4;
    localparam logic [2:0] REG_ROW2_OFFSET = 3'd5;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    // one numerator lane of the restoring divider
    typedef struct packed {
        logic [63:0]      rem;
        logic [QBITS-1:0] dlo;
        logic [QBITS-1:0] quo;
        logic             nneg;
        logic             nzero;
        logic             big;
    } lane_t;

    // one quotient bit per call
    function automatic lane_t div_step(lane_t l, logic [63:0] den);
        lane_t      r;
        logic [64:0] t;
        logic [64:0] d;
        r = l;
        t = {l.rem, l.dlo[QBITS-1]};
        d = {1'b0, den};
        r.dlo = {l.dlo[QBITS-2:0], 1'b0};
        if (t >= d) begin
            t = t - d;
            r.quo = {l.quo[QBITS-2:0], 1'b1};
        end else begin
            r.quo = {l.quo[QBITS-2:0], 1'b0};
        end
        r.rem = t[63:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/homography_point_map_unit.sv =====
// top level of the homography point map: affine sums, exact divide and saturation
// stages from input acceptance to the result on m_tdata:
//   (multiply, sum, magnitude, range check, 32 divide stages, output register)
// throughput: one item per cycle while the pipeline advances; the 32-stage restoring divider sets the depth
// the whole pipeline advances together whenever the output register is free or taken
// reset: synchronous active low, clears valid bits and loads the identity matrix
`default_nettype none
module homography_point_map_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input item
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // point_x [31:0], point_y [63:32]
    // result item
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // mapped_x [31:0], mapped_y [63:32]
    output logic [0:0]       m_tuser,   // out_of_range [0]
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    import hpm_pkg::*;

    localparam int DIV_STAGES = QBITS;
    localparam int DEPTH      = 4 + DIV_STAGES + 1;

    // matrix registers
    logic [63:0] lin_reg [3];
    logic [31:0] off_reg [3];
    logic [2:0]  cfg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lin_reg[0] <= 64'd1 << FRAC_BITS;
            lin_reg[1] <= 64'd1 << (FRAC_BITS + 32);
            lin_reg[2] <= 64'd0;
            off_reg[0] <= 32'd0;
            off_reg[1] <= 32'd0;
            off_reg[2] <= 32'd1 << FRAC_BITS;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ROW0_LINEAR: lin_reg[0] <= pwdata;
                REG_ROW0_OFFSET: off_reg[0] <= pwdata[31:0];
                REG_ROW1_LINEAR: lin_reg[1] <= pwdata;
                REG_ROW1_OFFSET: off_reg[1] <= pwdata[31:0];
                REG_ROW2_LINEAR: lin_reg[2] <= pwdata;
                REG_ROW2_OFFSET: off_reg[2] <= pwdata[31:0];
                default: ;  // writes beyond the last register are dropped
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ROW0_LINEAR: prdata = lin_reg[0];
            REG_ROW0_OFFSET: prdata = {32'd0, off_reg[0]};
            REG_ROW1_LINEAR: prdata = lin_reg[1];
            REG_ROW1_OFFSET: prdata = {32'd0, off_reg[1]};
            REG_ROW2_LINEAR: prdata = lin_reg[2];
            REG_ROW2_OFFSET: prdata = {32'd0, off_reg[2]};
            default:         prdata = 64'd0;
        endcase
    end

    // pipeline control: one enable for every stage
    logic             adv;
    logic [DEPTH-1:0] valid_reg;

    assign adv      = !valid_reg[DEPTH-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = valid_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[DEPTH-2:0], s_tvalid};
        end
    end

    // stage 1: the six products, 32x32 signed each
    logic signed [63:0] pa_reg [3];
    logic signed [63:0] pb_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                pa_reg[r] <= $signed(lin_reg[r][31:0])  * $signed(s_tdata[31:0]);
                pb_reg[r] <= $signed(lin_reg[r][63:32]) * $signed(s_tdata[63:32]);
            end
        end
    end

    // stage 2: exact row sums with twice the fraction bits
    logic [SUM_W-1:0] sum_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                sum_reg[r] <= {{2{pa_reg[r][63]}}, pa_reg[r]}
                            + {{2{pb_reg[r][63]}}, pb_reg[r]}
                            + {{(SUM_W - 32 - FRAC_BITS){off_reg[r][31]}}, off_reg[r],
                               {FRAC_BITS{1'b0}}};
            end
        end
    end

    // stage 3: sign and magnitude
    logic [63:0] mag_reg [3];
    logic        neg_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                logic [SUM_W-1:0] a;
                a = sum_reg[r][SUM_W-1] ? (SUM_W'(0) - sum_reg[r]) : sum_reg[r];
                mag_reg[r] <= a[63:0];
                neg_reg[r] <= sum_reg[r][SUM_W-1];
            end
        end
    end

    // stage 4: quotient range check and divider set-up, then the divide stages
    lane_t       lx_reg   [DIV_STAGES+1];
    lane_t       ly_reg   [DIV_STAGES+1];
    logic [63:0] den_reg  [DIV_STAGES+1];
    logic        dneg_reg [DIV_STAGES+1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 2; r++) begin
                lane_t l;
                l.rem   = {{SHIFT{1'b0}}, mag_reg[r][63:SHIFT]};
                l.dlo   = {mag_reg[r][SHIFT-1:0], {FRAC_BITS{1'b0}}};
                l.quo   = '0;
                l.nneg  = neg_reg[r];
                l.nzero = (mag_reg[r] == 64'd0);
                // quotient needs more than 32 bits
                l.big   = {{SHIFT{1'b0}}, mag_reg[r]} >= {mag_reg[2], {SHIFT{1'b0}}};
                if (r == 0) lx_reg[0] <= l;
                else        ly_reg[0] <= l;
            end
            den_reg[0]  <= mag_reg[2];
            dneg_reg[0] <= neg_reg[2];
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (adv) begin
                lx_reg[k+1]   <= div_step(lx_reg[k], den_reg[k]);
                ly_reg[k+1]   <= div_step(ly_reg[k], den_reg[k]);
                den_reg[k+1]  <= den_reg[k];
                dneg_reg[k+1] <= dneg_reg[k];
            end
        end
    end

    // output stage: signs, saturation and the flag
    logic [31:0] res_next [2];
    logic        flag_next [2];
    logic [31:0] outx_reg;
    logic [31:0] outy_reg;
    logic        oor_reg;

    always_comb begin
        for (int r = 0; r < 2; r++) begin
            lane_t l;
            logic  dz;
            logic  qneg;
            l    = (r == 0) ? lx_reg[DIV_STAGES] : ly_reg[DIV_STAGES];
            dz   = (den_reg[DIV_STAGES] == 64'd0);
            qneg = l.nneg ^ dneg_reg[DIV_STAGES];
            flag_next[r] = 1'b0;
            if (dz) begin
                flag_next[r] = 1'b1;
                res_next[r]  = l.nzero ? 32'd0 : (l.nneg ? SAT_NEG : SAT_POS);
            end else if (!qneg) begin
                if (l.big || l.quo[QBITS-1]) begin
                    flag_next[r] = 1'b1;
                    res_next[r]  = SAT_POS;
                end else begin
                    res_next[r]  = l.quo;
                end
            end else begin
                if (l.big || l.quo > SAT_NEG) begin
                    flag_next[r] = 1'b1;
                    res_next[r]  = SAT_NEG;
                end else begin
                    res_next[r]  = 32'd0 - l.quo;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            outx_reg <= res_next[0];
            outy_reg <= res_next[1];
            oor_reg  <= flag_next[0] | flag_next[1];
        end
    end

    assign m_tdata = {outy_reg, outx_reg};
    assign m_tuser = oor_reg;

    // a waiting result blocks new items
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while the output register is stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a new result appears only when the pipeline moved
    a_rise_on_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tready))
        else $error("result appeared without the pipeline advancing");

endmodule
`default_nettype wire
